// ----- hw/rtl/dlps_pkg.sv -----
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types, widths, codes and constant tables of the directional light
// Phong shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlps_pkg;

   localparam int VEC_W      = 16;
   localparam int COL_W      = 16;
   localparam int TINT_W     = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam int DOT_W  = 33;
   localparam int S_W    = 34;
   localparam int D14_W  = 18;
   localparam int DC_W   = 32;
   localparam int DD_W   = 50;
   localparam int SN_W   = 50;
   localparam int R_W    = 36;
   localparam int RP_W   = 52;
   localparam int RV_W   = 53;
   localparam int F_W    = 52;
   localparam int POS_W  = 6;
   localparam int MANT_W = 31;
   localparam int FRAC_W = 16;
   localparam int LG_W   = 23;
   localparam int PW_W   = 40;
   localparam int K_W    = 17;
   localparam int INT_W  = 64;
   localparam int DIFF_W = 24;
   localparam int CM_W   = 32;
   localparam int PP_W   = 64;
   localparam int SP_W   = 36;

   localparam int F_BIAS   = 42;
   localparam int NSTEP    = 16;
   localparam int LOG_LAT  = NSTEP + 2;
   localparam int EXP_LAT  = NSTEP + 2;
   localparam int SIDE_LAT = LOG_LAT + EXP_LAT;

   localparam logic [COL_W-1:0] COL_MAX = '1;

   localparam logic [1:0] MODE_LAMBERT = 2'd0;
   localparam logic [1:0] MODE_PHONG   = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X     = 3'd0,
      CSR_LIGHT_Y     = 3'd1,
      CSR_LIGHT_Z     = 3'd2,
      CSR_LIGHT_RED   = 3'd3,
      CSR_LIGHT_GREEN = 3'd4,
      CSR_LIGHT_BLUE  = 3'd5,
      CSR_SPEC_TINT   = 3'd6,
      CSR_SHININESS   = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic                   fz;
      logic [2:0][DIFF_W-1:0] diff;
   } side_type;

   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] v;
      r = '0;
      v = x;
      b = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-(i+1)) in Q1.30, built by repeated square roots
   function automatic logic [MANT_W-1:0] exp_factor(input int i);
      logic [63:0] c;
      c = isqrt(64'd2 << 60);
      for (int k = 1; k < NSTEP; k++) begin
         if (k <= i) c = isqrt(c << 30);
      end
      return c[MANT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dlps_req_if.sv -----
// ----------------------------------------------------------------------------
// dlps_req_if
// Request channel: one surface point per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dlps_req_if import dlps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              mode;
   logic [COL_W-1:0]        diffuse_red;
   logic [COL_W-1:0]        diffuse_green;
   logic [COL_W-1:0]        diffuse_blue;
   logic signed [VEC_W-1:0] normal_x;
   logic signed [VEC_W-1:0] normal_y;
   logic signed [VEC_W-1:0] normal_z;
   logic signed [VEC_W-1:0] view_x;
   logic signed [VEC_W-1:0] view_y;
   logic signed [VEC_W-1:0] view_z;

   modport source (
      output valid, mode, diffuse_red, diffuse_green, diffuse_blue,
             normal_x, normal_y, normal_z, view_x, view_y, view_z,
      input  ready
   );
   modport sink (
      input  valid, mode, diffuse_red, diffuse_green, diffuse_blue,
             normal_x, normal_y, normal_z, view_x, view_y, view_z,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/dlps_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dlps_rsp_if
// Response channel: one shaded color per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dlps_rsp_if import dlps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] out_red;
   logic [COL_W-1:0] out_green;
   logic [COL_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dlps_front.sv -----
// ----------------------------------------------------------------------------
// dlps_front
// Six-stage front end: N.L, diffuse term, reflected ray and R.V.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_front import dlps_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [1:0]              mode,
   input  wire logic [COL_W-1:0]        diffuse [3],
   input  wire logic signed [VEC_W-1:0] normal [3],
   input  wire logic signed [VEC_W-1:0] view [3],
   input  wire logic signed [VEC_W-1:0] light_dir [3],
   input  wire logic [COL_W-1:0]        light_col [3],
   output logic                         out_valid,
   output logic [F_W-1:0]               f,
   output side_type                     side
);

   logic [5:0] vld_ff;
   logic [1:0] mode1_ff, mode2_ff, mode3_ff, mode4_ff, mode5_ff, mode6_ff;

   logic signed [2*VEC_W-1:0] nl1_ff [3];
   logic [DC_W-1:0]           dc1_ff [3], dc2_ff [3];
   logic signed [VEC_W-1:0]   n1_ff [3], n2_ff [3];
   logic signed [VEC_W-1:0]   v1_ff [3], v2_ff [3], v3_ff [3], v4_ff [3];

   logic signed [DOT_W-1:0] dot, negd;
   logic signed [S_W-1:0]   s_in, s2_ff;
   logic [D14_W-1:0]        d14_in, d142_ff;

   logic signed [SN_W-1:0]  sn3_ff [3];
   logic [DD_W-1:0]         dd3_ff [3];
   logic signed [R_W-1:0]   r4_ff [3];
   logic [DIFF_W-1:0]       df4_ff [3], df5_ff [3], df6_ff [3];
   logic signed [RP_W-1:0]  rp5_ff [3];

   logic signed [RV_W-1:0]  rv;
   logic [F_W-1:0]          f_in, f6_ff;
   logic                    fz6_ff;

   assign dot    = DOT_W'(nl1_ff[0]) + DOT_W'(nl1_ff[1]) + DOT_W'(nl1_ff[2]);
   assign negd   = -dot;
   assign d14_in = dot[DOT_W-1] ? negd[31:14] : '0;
   assign s_in   = -$signed({dot, 1'b0});

   assign rv   = RV_W'(rp5_ff[0]) + RV_W'(rp5_ff[1]) + RV_W'(rp5_ff[2]);
   assign f_in = rv[RV_W-1] ? F_W'(-rv) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= mode;
         mode2_ff <= mode1_ff;
         mode3_ff <= mode2_ff;
         mode4_ff <= mode3_ff;
         mode5_ff <= mode4_ff;
         mode6_ff <= mode5_ff;
         s2_ff    <= s_in;
         d142_ff  <= d14_in;
         f6_ff    <= f_in;
         fz6_ff   <= (f_in == '0);
         for (int i = 0; i < 3; i++) begin
            nl1_ff[i] <= normal[i] * light_dir[i];
            dc1_ff[i] <= diffuse[i] * light_col[i];
            n1_ff[i]  <= normal[i];
            v1_ff[i]  <= view[i];
            dc2_ff[i] <= dc1_ff[i];
            n2_ff[i]  <= n1_ff[i];
            v2_ff[i]  <= v1_ff[i];
            sn3_ff[i] <= s2_ff * n2_ff[i];
            dd3_ff[i] <= dc2_ff[i] * d142_ff;
            v3_ff[i]  <= v2_ff[i];
            r4_ff[i]  <= R_W'($signed({light_dir[i], 14'b0})) + R_W'(sn3_ff[i] >>> 14);
            df4_ff[i] <= dd3_ff[i][DD_W-1:26];
            v4_ff[i]  <= v3_ff[i];
            rp5_ff[i] <= r4_ff[i] * v4_ff[i];
            df5_ff[i] <= df4_ff[i];
            df6_ff[i] <= df5_ff[i];
         end
      end
   end

   assign out_valid    = vld_ff[5];
   assign f            = f6_ff;
   assign side.mode    = mode6_ff;
   assign side.fz      = fz6_ff;
   assign side.diff[0] = df6_ff[0];
   assign side.diff[1] = df6_ff[1];
   assign side.diff[2] = df6_ff[2];

endmodule

`default_nettype wire

// ----- hw/rtl/dlps_log2.sv -----
// ----------------------------------------------------------------------------
// dlps_log2
// Pipelined log2: leading one search, normalize, one squaring per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_log2 import dlps_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [F_W-1:0]         f,
   output logic                        out_valid,
   output logic signed [LG_W-1:0]      lg
);

   logic             v0_ff;
   logic [F_W-1:0]   f0_ff;
   logic [POS_W-1:0] pos_in, pos0_ff;
   logic [F_W+29:0]  wide;

   logic              vld_ff  [NSTEP+1];
   logic [MANT_W-1:0] m_ff    [NSTEP+1];
   logic [FRAC_W-1:0] frac_ff [NSTEP+1];
   logic [POS_W-1:0]  pos_ff  [NSTEP+1];

   always_comb begin
      pos_in = '0;
      for (int j = 0; j < F_W; j++) begin
         if (f[j]) pos_in = POS_W'(j);
      end
   end

   assign wide = {f0_ff, 30'b0} >> pos0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         v0_ff     <= in_valid;
         vld_ff[0] <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_ff      <= f;
         pos0_ff    <= pos_in;
         m_ff[0]    <= wide[MANT_W-1:0];
         pos_ff[0]  <= pos0_ff;
         frac_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < NSTEP; g++) begin : g_step
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     t;

      assign sq = m_ff[g] * m_ff[g];
      assign t  = sq[2*MANT_W-1:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (en) begin
            vld_ff[g+1] <= vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[g+1]    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
            frac_ff[g+1] <= {frac_ff[g][FRAC_W-2:0], t[MANT_W]};
            pos_ff[g+1]  <= pos_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[NSTEP];
   assign lg = $signed({7'({1'b0, pos_ff[NSTEP]}) - 7'(F_BIAS), frac_ff[NSTEP]});

endmodule

`default_nettype wire

// ----- hw/rtl/dlps_exp2.sv -----
// ----------------------------------------------------------------------------
// dlps_exp2
// Pipelined power: scale by shininess, one root-of-two factor per stage,
// final binary shift with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_exp2 import dlps_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic signed [LG_W-1:0] lg,
   input  wire logic [COL_W-1:0]       shininess,
   output logic                        out_valid,
   output logic [INT_W-1:0]            intensity
);

   logic                   vld_ff [NSTEP+1];
   logic [MANT_W-1:0]      m_ff   [NSTEP+1];
   logic signed [PW_W-1:0] pw_ff  [NSTEP+1];
   logic signed [PW_W-1:0] pw_in;
   logic signed [K_W-1:0]  k;
   logic signed [K_W-1:0]  nk;
   logic [INT_W-1:0]       int_in, int_ff;
   logic                   vo_ff;

   assign pw_in = PW_W'(lg) * PW_W'($signed({1'b0, shininess}));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vo_ff     <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         vo_ff     <= vld_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pw_ff[0] <= pw_in;
         m_ff[0]  <= MANT_W'(1) << 30;
         int_ff   <= int_in;
      end
   end

   for (genvar g = 0; g < NSTEP; g++) begin : g_step
      localparam logic [MANT_W-1:0] FACTOR = exp_factor(g);
      logic [2*MANT_W-1:0] prod;

      assign prod = m_ff[g] * FACTOR;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (en) begin
            vld_ff[g+1] <= vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[g+1]  <= pw_ff[g][23-g] ? prod[2*MANT_W-2:30] : m_ff[g];
            pw_ff[g+1] <= pw_ff[g];
         end
      end
   end

   assign k  = K_W'(pw_ff[NSTEP] >>> 24) - K_W'(14);
   assign nk = -k;

   always_comb begin
      priority if (k > 17'sd32) begin
         int_in = '1;
      end else if (k >= 17'sd0) begin
         int_in = INT_W'(m_ff[NSTEP]) << k[5:0];
      end else if (k <= -17'sd63) begin
         int_in = '0;
      end else begin
         int_in = INT_W'(m_ff[NSTEP]) >> nk[5:0];
      end
   end

   assign out_valid = vo_ff;
   assign intensity = int_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/dlps_color.sv -----
// ----------------------------------------------------------------------------
// dlps_color
// Specular color product, overflow detect, sum with diffuse and saturate.
// The last stage is the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_color import dlps_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [INT_W-1:0]   intensity,
   input  wire side_type           side,
   input  wire logic [COL_W-1:0]   light_col [3],
   input  wire logic [TINT_W-1:0]  tint,
   input  wire logic [COL_W-1:0]   shininess,
   output logic                    out_valid,
   output logic [COL_W-1:0]        color [3]
);

   logic [3:0]       vld_ff;
   side_type         side1_ff, side2_ff, side3_ff;
   logic [INT_W-1:0] int_sel, int1_ff;
   logic [CM_W-1:0]  cm1_ff [3];
   logic [PP_W-1:0]  lo2_ff [3], hi2_ff [3];
   logic             ovf3_ff [3];
   logic [SP_W-1:0]  sp3_ff [3];
   logic [COL_W-1:0] col_ff [3];
   logic [COL_W-1:0] col_in [3];
   logic [PP_W:0]    hsum [3];

   always_comb begin
      if (side.fz) begin
         int_sel = (shininess == '0) ? INT_W'(65536) : '0;
      end else begin
         int_sel = intensity;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [DIFF_W:0] t;
         hsum[i] = {1'b0, hi2_ff[i]} + (PP_W+1)'(lo2_ff[i][PP_W-1:32]);
         t = {1'b0, side3_ff.diff[i]} + (DIFF_W+1)'(sp3_ff[i]);
         priority if (side3_ff.mode == MODE_PHONG) begin
            if (ovf3_ff[i] || sp3_ff[i] > SP_W'(COL_MAX)) begin
               col_in[i] = COL_MAX;
            end else if (t > (DIFF_W+1)'(COL_MAX)) begin
               col_in[i] = COL_MAX;
            end else begin
               col_in[i] = t[COL_W-1:0];
            end
         end else if (side3_ff.mode == MODE_LAMBERT) begin
            col_in[i] = (side3_ff.diff[i] > DIFF_W'(COL_MAX)) ? COL_MAX
                                                             : side3_ff.diff[i][COL_W-1:0];
         end else begin
            col_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         int1_ff  <= int_sel;
         for (int i = 0; i < 3; i++) begin
            cm1_ff[i]  <= tint[COL_W*i +: COL_W] * light_col[i];
            lo2_ff[i]  <= cm1_ff[i] * int1_ff[31:0];
            hi2_ff[i]  <= cm1_ff[i] * int1_ff[63:32];
            ovf3_ff[i] <= (hsum[i][PP_W:32] != '0);
            sp3_ff[i]  <= {hsum[i][31:0], lo2_ff[i][31:28]};
            col_ff[i]  <= col_in[i];
         end
      end
   end

   assign out_valid = vld_ff[3];
   assign color[0]  = col_ff[0];
   assign color[1]  = col_ff[1];
   assign color[2]  = col_ff[2];

endmodule

`default_nettype wire

// ----- hw/rtl/directional_light_phong_shade.sv -----
// ----------------------------------------------------------------------------
// directional_light_phong_shade
// Phong shading of one surface point under a directional light.
//
// req_ch carries mode, diffuse color, normal and view direction; rsp_ch
// returns the saturated color. The csr_ port writes light direction, light
// color, specular tint and shininess; write it only while no item is in
// flight.
// The block is one 46-stage pipeline: front end 6, log2 18 (one squaring
// per stage), power 18 (one root-of-two multiply per stage), color 4.
// One item is accepted every cycle while the receiver keeps up.
// When rsp_ch stalls with a result waiting, the whole pipeline holds,
// empty stages included, and req_ch.ready drops until the result is taken.
// Reset clears all valid bits and loads the register defaults: light along
// minus y, white light, black tint, shininess 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module directional_light_phong_shade import dlps_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   dlps_req_if.sink                   req_ch,
   dlps_rsp_if.source                 rsp_ch
);

   logic signed [VEC_W-1:0] light_dir_ff [3];
   logic [COL_W-1:0]        light_col_ff [3];
   logic [TINT_W-1:0]       tint_ff;
   logic [COL_W-1:0]        shin_ff;

   logic                    en;
   logic [COL_W-1:0]        diffuse [3];
   logic signed [VEC_W-1:0] normal [3];
   logic signed [VEC_W-1:0] view [3];

   logic                    front_valid, log_valid, exp_valid;
   logic [F_W-1:0]          front_f;
   side_type                front_side;
   logic signed [LG_W-1:0]  lg;
   logic [INT_W-1:0]        intensity;
   side_type                side_ff [SIDE_LAT];
   logic [COL_W-1:0]        color [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         light_dir_ff[0] <= 16'sd0;
         light_dir_ff[1] <= -16'sd16384;
         light_dir_ff[2] <= 16'sd0;
         light_col_ff[0] <= 16'd4096;
         light_col_ff[1] <= 16'd4096;
         light_col_ff[2] <= 16'd4096;
         tint_ff         <= '0;
         shin_ff         <= 16'd256;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LIGHT_X:     light_dir_ff[0] <= csr_wr_data[VEC_W-1:0];
            CSR_LIGHT_Y:     light_dir_ff[1] <= csr_wr_data[VEC_W-1:0];
            CSR_LIGHT_Z:     light_dir_ff[2] <= csr_wr_data[VEC_W-1:0];
            CSR_LIGHT_RED:   light_col_ff[0] <= csr_wr_data[COL_W-1:0];
            CSR_LIGHT_GREEN: light_col_ff[1] <= csr_wr_data[COL_W-1:0];
            CSR_LIGHT_BLUE:  light_col_ff[2] <= csr_wr_data[COL_W-1:0];
            CSR_SPEC_TINT:   tint_ff         <= csr_wr_data[TINT_W-1:0];
            CSR_SHININESS:   shin_ff         <= csr_wr_data[COL_W-1:0];
            default:         shin_ff         <= shin_ff;
         endcase
      end
   end

   // advance everything unless a finished result waits
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   assign diffuse[0] = req_ch.diffuse_red;
   assign diffuse[1] = req_ch.diffuse_green;
   assign diffuse[2] = req_ch.diffuse_blue;
   assign normal[0]  = req_ch.normal_x;
   assign normal[1]  = req_ch.normal_y;
   assign normal[2]  = req_ch.normal_z;
   assign view[0]    = req_ch.view_x;
   assign view[1]    = req_ch.view_y;
   assign view[2]    = req_ch.view_z;

   dlps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .mode      (req_ch.mode),
      .diffuse   (diffuse),
      .normal    (normal),
      .view      (view),
      .light_dir (light_dir_ff),
      .light_col (light_col_ff),
      .out_valid (front_valid),
      .f         (front_f),
      .side      (front_side)
   );

   dlps_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .f         (front_f),
      .out_valid (log_valid),
      .lg        (lg)
   );

   dlps_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (log_valid),
      .lg        (lg),
      .shininess (shin_ff),
      .out_valid (exp_valid),
      .intensity (intensity)
   );

   // carry mode and diffuse terms alongside the log and power stages
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= front_side;
         for (int i = 1; i < SIDE_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   dlps_color u_color (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (exp_valid),
      .intensity (intensity),
      .side      (side_ff[SIDE_LAT-1]),
      .light_col (light_col_ff),
      .tint      (tint_ff),
      .shininess (shin_ff),
      .out_valid (rsp_ch.valid),
      .color     (color)
   );

   assign rsp_ch.out_red   = color[0];
   assign rsp_ch.out_green = color[1];
   assign rsp_ch.out_blue  = color[2];

endmodule

`default_nettype wire

// ----- tb/directional_light_phong_shade_check.sv -----
// ----------------------------------------------------------------------------
// directional_light_phong_shade_check
// Watches the request and response channels of the shader. Computes the
// expected color of every accepted item with its own copy of the light
// registers, queues it, and compares each accepted response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directional_light_phong_shade_check import dlps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   dlps_req_if.sink              req_ch,
   dlps_rsp_if.sink              rsp_ch,
   output int                    errors,
   output int                    pending
);

   typedef struct {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
   } color_type;

   color_type shade_q[$];

   logic signed [15:0] light_dir[3];
   logic [15:0]        light_col[3];
   logic [47:0]        tint;
   logic [15:0]        shine;
   logic [63:0]        root_tab[16];

   function automatic logic [63:0] sqrt64(input logic [63:0] x);
      logic [63:0] r, b, v;
      r = 0;
      v = x;
      b = 64'h4000_0000_0000_0000;
      while (b > v && b != 0) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint floor_shr(input longint x, input int k);
      return x >>> k;
   endfunction

   function automatic longint log2_fix(input logic [63:0] f);
      int p;
      logic [63:0] m;
      longint fr;
      p = 63;
      fr = 0;
      while (!f[p]) p--;
      if (p >= 30) m = f >> (p - 30);
      else m = f << (30 - p);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         fr = fr << 1;
         if (m >= (64'd1 << 31)) begin
            fr = fr | 1;
            m = m >> 1;
         end
      end
      return longint'(p - 42) * 65536 + fr;
   endfunction

   function automatic logic [63:0] exp2_fix(input longint pw);
      logic [63:0] m;
      logic [23:0] fr;
      longint k;
      m = 64'd1 << 30;
      fr = pw[23:0];
      k = floor_shr(pw, 24) - 14;
      for (int i = 0; i < 16; i++) if (fr[23 - i]) m = (m * root_tab[i]) >> 30;
      if (k > 32) return '1;
      if (k >= 0) return m << k;
      if (k <= -63) return 0;
      return m >> (-k);
   endfunction

   function automatic color_type shade(input logic [1:0] mode,
                                       input logic [15:0] dif[3],
                                       input logic signed [15:0] nv[3],
                                       input logic signed [15:0] vv[3]);
      longint dot, rv, s, ri;
      logic [63:0] d14, inten, f, total, lc, sc, cm, sp;
      logic [15:0] res[3];
      color_type c;
      dot = 0;
      rv = 0;
      inten = 0;
      for (int i = 0; i < 3; i++) dot += longint'(nv[i]) * longint'(light_dir[i]);
      d14 = dot < 0 ? (64'(-dot) >> 14) : 0;
      if (mode == MODE_PHONG) begin
         s = -2 * dot;
         for (int i = 0; i < 3; i++) begin
            ri = longint'(light_dir[i]) * 16384 + floor_shr(s * longint'(nv[i]), 14);
            rv += ri * longint'(vv[i]);
         end
         f = rv < 0 ? 64'(-rv) : 0;
         if (f == 0) inten = shine == 0 ? 65536 : 0;
         else inten = exp2_fix(log2_fix(f) * longint'(shine));
      end
      for (int i = 0; i < 3; i++) begin
         total = 0;
         if (mode == MODE_LAMBERT || mode == MODE_PHONG) begin
            lc = 64'(light_col[i]);
            total = (64'(dif[i]) * lc * d14) >> 26;
            if (mode == MODE_PHONG) begin
               sc = 64'((tint >> (16 * i)) & 48'hFFFF);
               cm = sc * lc;
               if (cm != 0) begin
                  if (inten > 64'hFFFF_FFFF_FFFF_FFFF / cm) total = 65535;
                  else begin
                     sp = (cm * inten) >> 28;
                     total = sp > 65535 ? 65535 : total + sp;
                  end
               end
            end
         end
         res[i] = total > 65535 ? 16'hFFFF : total[15:0];
      end
      c.red = res[0];
      c.green = res[1];
      c.blue = res[2];
      return c;
   endfunction

   initial begin
      root_tab[0] = sqrt64(64'd2 << 60);
      for (int i = 1; i < 16; i++) root_tab[i] = sqrt64(root_tab[i - 1] << 30);
   end

   always @(posedge clock) begin
      logic [15:0] dif[3];
      logic signed [15:0] nv[3], vv[3];
      color_type got, want;
      if (reset) begin
         light_dir[0] <= 0;
         light_dir[1] <= -16'sd16384;
         light_dir[2] <= 0;
         for (int i = 0; i < 3; i++) light_col[i] <= 16'd4096;
         tint <= 0;
         shine <= 16'd256;
         errors <= 0;
         pending <= 0;
         shade_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_LIGHT_X:     light_dir[0] <= csr_wr_data[15:0];
               CSR_LIGHT_Y:     light_dir[1] <= csr_wr_data[15:0];
               CSR_LIGHT_Z:     light_dir[2] <= csr_wr_data[15:0];
               CSR_LIGHT_RED:   light_col[0] <= csr_wr_data[15:0];
               CSR_LIGHT_GREEN: light_col[1] <= csr_wr_data[15:0];
               CSR_LIGHT_BLUE:  light_col[2] <= csr_wr_data[15:0];
               CSR_SPEC_TINT:   tint <= csr_wr_data[47:0];
               CSR_SHININESS:   shine <= csr_wr_data[15:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            dif[0] = req_ch.diffuse_red;
            dif[1] = req_ch.diffuse_green;
            dif[2] = req_ch.diffuse_blue;
            nv[0] = req_ch.normal_x;
            nv[1] = req_ch.normal_y;
            nv[2] = req_ch.normal_z;
            vv[0] = req_ch.view_x;
            vv[1] = req_ch.view_y;
            vv[2] = req_ch.view_z;
            shade_q.push_back(shade(req_ch.mode, dif, nv, vv));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.red = rsp_ch.out_red;
            got.green = rsp_ch.out_green;
            got.blue = rsp_ch.out_blue;
            if (shade_q.size() == 0) begin
               $display("%0t: unexpected item %h %h %h", $time,
                        got.red, got.green, got.blue);
               errors <= errors + 1;
            end else begin
               want = shade_q.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue) begin
                  $display("%0t: expected %h %h %h actual %h %h %h", $time,
                           want.red, want.green, want.blue,
                           got.red, got.green, got.blue);
                  errors <= errors + 1;
               end
            end
         end
         pending <= int'(shade_q.size());
      end
   end

endmodule

// ----- tb/directional_light_phong_shade_test.sv -----
// ----------------------------------------------------------------------------
// directional_light_phong_shade_test
// Drives the shader with directed and random surface points under several
// light settings, with bursty input and a stalling receiver; the checker
// beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directional_light_phong_shade_test;
   import dlps_pkg::*;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   int                    errors, pending;
   int                    hold_off = 0;
   bit                    finished = 0;

   dlps_req_if req_ch ();
   dlps_rsp_if rsp_ch ();

   directional_light_phong_shade uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   directional_light_phong_shade_check checker_inst (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.sink),
      .errors(errors), .pending(pending)
   );

   always #1 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.mode = 0;
      req_ch.diffuse_red = 0;
      req_ch.diffuse_green = 0;
      req_ch.diffuse_blue = 0;
      req_ch.normal_x = 0;
      req_ch.normal_y = 0;
      req_ch.normal_z = 0;
      req_ch.view_x = 0;
      req_ch.view_y = 0;
      req_ch.view_z = 0;
      rsp_ch.ready = 0;
   end

   // receiver stall pattern, with a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ch.ready <= 0;
         hold_off <= hold_off - 1;
      end else if (finished) begin
         rsp_ch.ready <= 1;
      end else begin
         case (($time / 400) % 3)
            0: rsp_ch.ready <= 1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [47:0] value);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_point(input logic [1:0] mode, input logic [47:0] dif,
                             input logic [47:0] nv, input logic [47:0] vv);
      req_ch.valid <= 1;
      req_ch.mode <= mode;
      {req_ch.diffuse_blue, req_ch.diffuse_green, req_ch.diffuse_red} <= dif;
      {req_ch.normal_z, req_ch.normal_y, req_ch.normal_x} <= nv;
      {req_ch.view_z, req_ch.view_y, req_ch.view_x} <= vv;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_vec();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h4000;
         3: return 16'hC000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [47:0] rand_trip();
      return {rand_vec(), rand_vec(), rand_vec()};
   endfunction

   task automatic random_points(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            send_point(($urandom_range(0, 9) < 4) ? MODE_LAMBERT :
                       ($urandom_range(0, 9) < 9) ? MODE_PHONG : 2'($urandom_range(2, 3)),
                       48'({$urandom(), $urandom()}), rand_trip(), rand_trip());
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_ch.valid <= 0;
   endtask

   task automatic load_light(input logic [47:0] dir, input logic [47:0] col,
                             input logic [47:0] tint_val, input logic [15:0] shine_val);
      write_reg(CSR_LIGHT_X, 48'(dir[15:0]));
      write_reg(CSR_LIGHT_Y, 48'(dir[31:16]));
      write_reg(CSR_LIGHT_Z, 48'(dir[47:32]));
      write_reg(CSR_LIGHT_RED, 48'(col[15:0]));
      write_reg(CSR_LIGHT_GREEN, 48'(col[31:16]));
      write_reg(CSR_LIGHT_BLUE, 48'(col[47:32]));
      write_reg(CSR_SPEC_TINT, tint_val);
      write_reg(CSR_SHININESS, 48'(shine_val));
      csr_wr_en <= 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // defaults: light down minus y
      send_point(MODE_LAMBERT, {3{16'h1000}}, {16'h0, 16'h4000, 16'h0}, 48'h0);
      send_point(MODE_PHONG, {3{16'hFFFF}}, {16'h0, 16'h4000, 16'h0},
                 {16'h0, 16'hC000, 16'h0});
      send_point(2'd2, {3{16'hFFFF}}, {16'h0, 16'h4000, 16'h0}, 48'h0);
      send_point(2'd3, {3{16'hFFFF}}, {16'h0, 16'h4000, 16'h0}, 48'h0);
      req_ch.valid <= 0;
      drain();
      load_light({16'h0, 16'hC000, 16'h0}, {3{16'h1000}},
                 {16'h1000, 16'h0800, 16'h2000}, 16'd0);
      send_point(MODE_PHONG, {3{16'h1000}}, {16'h0, 16'h4000, 16'h0}, 48'h0);
      send_point(MODE_PHONG, {3{16'h1000}}, {16'h0, 16'h4000, 16'h0},
                 {16'h0, 16'h4000, 16'h0});
      req_ch.valid <= 0;
      drain();
      load_light({16'h7FFF, 16'h8000, 16'h7FFF}, {3{16'hFFFF}}, '1, 16'hFFFF);
      send_point(MODE_PHONG, {3{16'hFFFF}}, {16'h8000, 16'h7FFF, 16'h8000},
                 {16'h7FFF, 16'h8000, 16'h7FFF});
      send_point(MODE_PHONG, {3{16'hFFFF}}, {16'h0020, 16'h0, 16'h0},
                 {16'h0001, 16'h0, 16'h0});
      send_point(MODE_LAMBERT, {3{16'hFFFF}}, {16'h8000, 16'h7FFF, 16'h8000}, 48'h0);
      send_point(MODE_LAMBERT, 48'h0, {3{16'h8000}}, {3{16'h8000}});
      req_ch.valid <= 0;
      drain();
      load_light({16'h0, 16'hC000, 16'h0}, {3{16'h1000}}, '1, 16'h0001);
      send_point(MODE_PHONG, {3{16'h1000}}, {16'h0, 16'h4000, 16'h0},
                 {16'h0, 16'hC000, 16'h0});
      send_point(MODE_PHONG, {3{16'h1000}}, {16'h2D41, 16'h2D41, 16'h0},
                 {16'h0, 16'hC000, 16'h0});
      req_ch.valid <= 0;
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         load_light(rand_trip(), 48'({$urandom(), $urandom()}),
                    48'({$urandom(), $urandom()}),
                    (phase == 0) ? 16'h0100 : (phase == 1) ? 16'h2000 :
                    16'($urandom_range(0, 65535)));
         if (phase == 1) begin
            hold_off <= 300;
            @(posedge clock);
         end
         random_points(200);
         drain();
      end
      finished = 1;
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("directional_light_phong_shade: match");
      else
         $display("directional_light_phong_shade: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("directional_light_phong_shade: mismatch");
      $finish;
   end

endmodule
